@@ rtl/cfsc_pkg.sv @@
// package with codes, field widths, lookup functions and bcd conversion for the clock setter
`default_nettype none
package cfsc_pkg;

	localparam int YEAR_W    = 7;
	localparam int MONTH_W   = 4;
	localparam int DAY_W     = 5;
	localparam int WEEKDAY_W = 3;
	localparam int HOUR_W    = 5;
	localparam int MINUTE_W  = 6;
	localparam int SECOND_W  = 6;
	localparam int VAL_W     = 7;
	localparam int SEL_W     = 3;
	localparam int CMD_W     = 3;

	localparam int SNAP_W      = YEAR_W + MONTH_W + DAY_W + WEEKDAY_W + HOUR_W + MINUTE_W
		+ SECOND_W;
	localparam int IN_TDATA_W  = ((SNAP_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = 24;
	localparam int OUT_TUSER_W = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD = 3'd0,
		CMD_MODE = 3'd1,
		CMD_NEXT = 3'd2,
		CMD_UP   = 3'd3,
		CMD_DOWN = 3'd4
	} cmd_t;

	typedef enum logic [SEL_W-1:0] {
		SEL_YEAR    = 3'd0,
		SEL_MONTH   = 3'd1,
		SEL_DAY     = 3'd2,
		SEL_WEEKDAY = 3'd3,
		SEL_HOUR    = 3'd4,
		SEL_MINUTE  = 3'd5,
		SEL_SECOND  = 3'd6
	} sel_t;

	localparam logic [7:0] LCD_CURSOR_ON  = 8'h0F;
	localparam logic [7:0] LCD_CURSOR_OFF = 8'h0C;
	localparam logic [7:0] CURSOR_YEAR    = 8'h80 + 8'd4;
	localparam logic [7:0] CURSOR_MONTH   = 8'h80 + 8'd7;
	localparam logic [7:0] CURSOR_DAY     = 8'h80 + 8'd10;
	localparam logic [7:0] CURSOR_WEEKDAY = 8'h80 + 8'd14;
	localparam logic [7:0] CURSOR_HOUR    = 8'hC0 + 8'd5;
	localparam logic [7:0] CURSOR_MINUTE  = 8'hC0 + 8'd8;
	localparam logic [7:0] CURSOR_SECOND  = 8'hC0 + 8'd11;

	localparam logic [3:0] RTC_SECOND  = 4'd2;
	localparam logic [3:0] RTC_MINUTE  = 4'd3;
	localparam logic [3:0] RTC_HOUR    = 4'd4;
	localparam logic [3:0] RTC_DAY     = 4'd5;
	localparam logic [3:0] RTC_WEEKDAY = 4'd6;
	localparam logic [3:0] RTC_MONTH   = 4'd7;
	localparam logic [3:0] RTC_YEAR    = 4'd8;

	localparam logic [SEL_W-1:0] SEL_LAST = SEL_SECOND;

	function automatic logic [7:0] field_cursor(input logic [SEL_W-1:0] sel);
		case (sel)
			SEL_YEAR:    field_cursor = CURSOR_YEAR;
			SEL_MONTH:   field_cursor = CURSOR_MONTH;
			SEL_DAY:     field_cursor = CURSOR_DAY;
			SEL_WEEKDAY: field_cursor = CURSOR_WEEKDAY;
			SEL_HOUR:    field_cursor = CURSOR_HOUR;
			SEL_MINUTE:  field_cursor = CURSOR_MINUTE;
			default:     field_cursor = CURSOR_SECOND;
		endcase
	endfunction

	function automatic logic [3:0] field_addr(input logic [SEL_W-1:0] sel);
		case (sel)
			SEL_YEAR:    field_addr = RTC_YEAR;
			SEL_MONTH:   field_addr = RTC_MONTH;
			SEL_DAY:     field_addr = RTC_DAY;
			SEL_WEEKDAY: field_addr = RTC_WEEKDAY;
			SEL_HOUR:    field_addr = RTC_HOUR;
			SEL_MINUTE:  field_addr = RTC_MINUTE;
			default:     field_addr = RTC_SECOND;
		endcase
	endfunction

	function automatic logic [VAL_W-1:0] field_min(input logic [SEL_W-1:0] sel);
		case (sel)
			SEL_MONTH, SEL_DAY, SEL_WEEKDAY: field_min = 7'd1;
			default:                         field_min = 7'd0;
		endcase
	endfunction

	function automatic logic [VAL_W-1:0] field_max(input logic [SEL_W-1:0] sel);
		case (sel)
			SEL_YEAR:    field_max = 7'd99;
			SEL_MONTH:   field_max = 7'd12;
			SEL_DAY:     field_max = 7'd31;
			SEL_WEEKDAY: field_max = 7'd7;
			SEL_HOUR:    field_max = 7'd23;
			default:     field_max = 7'd59;
		endcase
	endfunction

	// tens by multiply with 205/2048, exact below 1029
	function automatic logic [7:0] to_bcd(input logic [VAL_W-1:0] v);
		logic [17:0]      prod;
		logic [3:0]       tens;
		logic [VAL_W-1:0] ones;
		prod = 18'(v) * 18'd205;
		tens = prod[14:11];
		ones = v - VAL_W'(VAL_W'(tens) * VAL_W'(10));
		to_bcd = {tens, ones[3:0]};
	endfunction

endpackage
`default_nettype wire

@@ rtl/clock_field_set_controller.sv @@
// key-driven time field setting controller with stream ports
// an accepted input transaction passes the input register and then the result register
// throughput: one transaction per cycle while m_axis_tready does not stall the result;
// the field update between the input register and the result register is combinational
// reset: arst_n clears the handshake state, edit mode and the cursor; month, day and
// weekday come up as 1, the other fields as 0
`default_nettype none
module clock_field_set_controller (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// year, month, day, weekday, hour, minute, second, zero pad
	input  wire logic [cfsc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// cmd
	input  wire logic [cfsc_pkg::CMD_W-1:0]       s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// edit_mode, field_sel, reg_addr, reg_data, lcd_byte
	output logic [cfsc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
	// reg_write, lcd_valid, lcd_extra
	output logic [cfsc_pkg::OUT_TUSER_W-1:0]      m_axis_tuser
);
	import cfsc_pkg::*;

	logic                 valid_s1;
	logic [CMD_W-1:0]     cmd_s1;
	logic [SNAP_W-1:0]    snap_s1;
	logic                 advance;

	logic                 edit_q, edit_d;
	logic [SEL_W-1:0]     sel_q, sel_d;
	logic [YEAR_W-1:0]    year_q, year_d;
	logic [MONTH_W-1:0]   month_q, month_d;
	logic [DAY_W-1:0]     day_q, day_d;
	logic [WEEKDAY_W-1:0] weekday_q, weekday_d;
	logic [HOUR_W-1:0]    hour_q, hour_d;
	logic [MINUTE_W-1:0]  minute_q, minute_d;
	logic [SECOND_W-1:0]  second_q, second_d;

	logic [VAL_W-1:0]     cur_val, lo_val, hi_val, new_val;
	logic                 reg_write, lcd_valid, lcd_extra;
	logic [3:0]           reg_addr;
	logic [7:0]           reg_data, lcd_byte;

	logic                 m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;
	logic [OUT_TUSER_W-1:0] m_user_q;

	assign advance       = valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_s1  <= s_axis_tuser;
			snap_s1 <= s_axis_tdata[SNAP_W-1:0];
		end
	end

	always_comb begin
		case (sel_q)
			SEL_YEAR:    cur_val = year_q;
			SEL_MONTH:   cur_val = VAL_W'(month_q);
			SEL_DAY:     cur_val = VAL_W'(day_q);
			SEL_WEEKDAY: cur_val = VAL_W'(weekday_q);
			SEL_HOUR:    cur_val = VAL_W'(hour_q);
			SEL_MINUTE:  cur_val = VAL_W'(minute_q);
			default:     cur_val = VAL_W'(second_q);
		endcase
		lo_val = field_min(sel_q);
		hi_val = field_max(sel_q);
		if (cmd_s1 == CMD_UP) begin
			new_val = (cur_val >= hi_val) ? lo_val : cur_val + 7'd1;
		end else begin
			new_val = (cur_val <= lo_val || cur_val > hi_val) ? hi_val : cur_val - 7'd1;
		end
	end

	always_comb begin
		edit_d    = edit_q;
		sel_d     = sel_q;
		year_d    = year_q;
		month_d   = month_q;
		day_d     = day_q;
		weekday_d = weekday_q;
		hour_d    = hour_q;
		minute_d  = minute_q;
		second_d  = second_q;
		reg_write = 1'b0;
		reg_addr  = '0;
		reg_data  = '0;
		lcd_valid = 1'b0;
		lcd_byte  = '0;
		lcd_extra = 1'b0;
		case (cmd_s1)
			CMD_LOAD: begin
				if (!edit_q) begin
					{second_d, minute_d, hour_d, weekday_d, day_d, month_d, year_d} = snap_s1;
				end
			end
			CMD_MODE: begin
				edit_d    = !edit_q;
				lcd_valid = 1'b1;
				if (!edit_q) begin
					sel_d     = SEL_YEAR;
					lcd_byte  = CURSOR_YEAR;
					lcd_extra = 1'b1;
				end else begin
					lcd_byte = LCD_CURSOR_OFF;
				end
			end
			CMD_NEXT: begin
				if (edit_q) begin
					sel_d     = (sel_q >= SEL_LAST) ? SEL_YEAR : sel_q + 3'd1;
					lcd_valid = 1'b1;
					lcd_byte  = field_cursor(sel_d);
				end
			end
			CMD_UP, CMD_DOWN: begin
				if (edit_q && sel_q <= SEL_LAST) begin
					case (sel_q)
						SEL_YEAR:    year_d    = new_val;
						SEL_MONTH:   month_d   = new_val[MONTH_W-1:0];
						SEL_DAY:     day_d     = new_val[DAY_W-1:0];
						SEL_WEEKDAY: weekday_d = new_val[WEEKDAY_W-1:0];
						SEL_HOUR:    hour_d    = new_val[HOUR_W-1:0];
						SEL_MINUTE:  minute_d  = new_val[MINUTE_W-1:0];
						default:     second_d  = new_val[SECOND_W-1:0];
					endcase
					reg_write = 1'b1;
					reg_addr  = field_addr(sel_q);
					reg_data  = to_bcd(new_val);
					lcd_valid = 1'b1;
					lcd_byte  = field_cursor(sel_q);
				end
			end
			default: begin
			end
		endcase
	end

	// field state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edit_q    <= 1'b0;
			sel_q     <= SEL_YEAR;
			year_q    <= '0;
			month_q   <= MONTH_W'(1);
			day_q     <= DAY_W'(1);
			weekday_q <= WEEKDAY_W'(1);
			hour_q    <= '0;
			minute_q  <= '0;
			second_q  <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				edit_q    <= edit_d;
				sel_q     <= sel_d;
				year_q    <= year_d;
				month_q   <= month_d;
				day_q     <= day_d;
				weekday_q <= weekday_d;
				hour_q    <= hour_d;
				minute_q  <= minute_d;
				second_q  <= second_d;
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_data_q <= {lcd_byte, reg_data, reg_addr, sel_d, edit_d};
			m_user_q <= {lcd_extra, lcd_valid, reg_write};
		end
	end

endmodule
`default_nettype wire

@@ rtl/cfsc_checker.sv @@
// port-level checker for the clock setter and its bind
`default_nettype none
module cfsc_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              m_axis_tvalid,
	input wire logic                              m_axis_tready,
	input wire logic [cfsc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	input wire logic [cfsc_pkg::OUT_TUSER_W-1:0]  m_axis_tuser
);
	import cfsc_pkg::*;

	logic       edit_mode, reg_write, lcd_valid, lcd_extra;
	logic [2:0] field_sel;
	logic [3:0] reg_addr;
	logic [7:0] lcd_byte;

	assign edit_mode = m_axis_tdata[0];
	assign field_sel = m_axis_tdata[3:1];
	assign reg_addr  = m_axis_tdata[7:4];
	assign lcd_byte  = m_axis_tdata[23:16];
	assign reg_write = m_axis_tuser[0];
	assign lcd_valid = m_axis_tuser[1];
	assign lcd_extra = m_axis_tuser[2];

	// a stalled result transaction stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result transaction dropped while stalled");

	// mode entry shows the year cursor with edit mode on
	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && lcd_extra |-> lcd_valid && edit_mode && field_sel == SEL_YEAR
			&& lcd_byte == CURSOR_YEAR && !reg_write)
		else $error("bad mode entry result");

	// a register write only in edit mode, with a cursor and a valid rtc address
	a_write: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && reg_write |-> edit_mode && lcd_valid && !lcd_extra
			&& (reg_addr == RTC_SECOND || reg_addr == RTC_MINUTE || reg_addr == RTC_HOUR
			|| reg_addr == RTC_DAY || reg_addr == RTC_WEEKDAY || reg_addr == RTC_MONTH
			|| reg_addr == RTC_YEAR))
		else $error("bad register write result");

	// cursor off only when leaving edit mode
	a_leave: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && lcd_valid && lcd_byte == LCD_CURSOR_OFF |-> !edit_mode)
		else $error("cursor off while in edit mode");

endmodule

bind clock_field_set_controller cfsc_checker u_cfsc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

@@ dv/clock_field_set_controller_tb.sv @@
// testbench for the clock field setter: stream stimulus, prediction and checking of results
`timescale 1ns / 1ps
module clock_field_set_controller_tb;
	import cfsc_pkg::*;

	typedef struct packed {
		logic       edit_mode;
		logic [2:0] field_sel;
		logic       reg_write;
		logic [3:0] reg_addr;
		logic [7:0] reg_data;
		logic       lcd_valid;
		logic [7:0] lcd_byte;
		logic       lcd_extra;
	} clock_result_t;

	class clock_setter_scoreboard;
		clock_result_t setting_q[$];
		logic          edit_on;
		sel_t          cursor_sel;
		logic [6:0]    field_val[7];
		logic [6:0]    val_lo[7] = '{7'd0, 7'd1, 7'd1, 7'd1, 7'd0, 7'd0, 7'd0};
		logic [6:0]    val_hi[7] = '{7'd99, 7'd12, 7'd31, 7'd7, 7'd23, 7'd59, 7'd59};
		logic [7:0]    cursor_of[7] = '{CURSOR_YEAR, CURSOR_MONTH, CURSOR_DAY, CURSOR_WEEKDAY,
			CURSOR_HOUR, CURSOR_MINUTE, CURSOR_SECOND};
		logic [3:0]    rtc_of[7] = '{RTC_YEAR, RTC_MONTH, RTC_DAY, RTC_WEEKDAY, RTC_HOUR,
			RTC_MINUTE, RTC_SECOND};
		int            mismatches;

		function new();
			edit_on = 1'b0;
			cursor_sel = SEL_YEAR;
			field_val = '{7'd0, 7'd1, 7'd1, 7'd1, 7'd0, 7'd0, 7'd0};
			mismatches = 0;
		endfunction

		function int outstanding();
			return setting_q.size();
		endfunction

		// returns 1 when the transaction changed state or produced a display or write request
		function bit note_input(logic [CMD_W-1:0] cmd, logic [IN_TDATA_W-1:0] data);
			clock_result_t r;
			bit            acted;
			sel_t          s;
			logic [6:0]    v;
			r = '0;
			acted = 1'b0;
			case (cmd)
				CMD_LOAD: if (!edit_on) begin
					field_val[SEL_YEAR]    = data[6:0];
					field_val[SEL_MONTH]   = 7'(data[10:7]);
					field_val[SEL_DAY]     = 7'(data[15:11]);
					field_val[SEL_WEEKDAY] = 7'(data[18:16]);
					field_val[SEL_HOUR]    = 7'(data[23:19]);
					field_val[SEL_MINUTE]  = 7'(data[29:24]);
					field_val[SEL_SECOND]  = 7'(data[35:30]);
					acted = 1'b1;
				end
				CMD_MODE: begin
					edit_on = !edit_on;
					r.lcd_valid = 1'b1;
					if (edit_on) begin
						cursor_sel = SEL_YEAR;
						r.lcd_byte = cursor_of[SEL_YEAR];
						r.lcd_extra = 1'b1;
					end else begin
						r.lcd_byte = LCD_CURSOR_OFF;
					end
					acted = 1'b1;
				end
				CMD_NEXT: if (edit_on) begin
					cursor_sel = (cursor_sel >= SEL_LAST) ? SEL_YEAR : sel_t'(cursor_sel + 3'd1);
					r.lcd_valid = 1'b1;
					r.lcd_byte = cursor_of[cursor_sel];
					acted = 1'b1;
				end
				CMD_UP, CMD_DOWN: if (edit_on) begin
					s = cursor_sel;
					v = field_val[s];
					if (cmd == CMD_UP)
						v = (v >= val_hi[s]) ? val_lo[s] : v + 7'd1;
					else
						v = (v <= val_lo[s] || v > val_hi[s]) ? val_hi[s] : v - 7'd1;
					field_val[s] = v;
					r.reg_write = 1'b1;
					r.reg_addr = rtc_of[s];
					r.reg_data = {4'(v / 7'd10), 4'(v % 7'd10)};
					r.lcd_valid = 1'b1;
					r.lcd_byte = cursor_of[s];
					acted = 1'b1;
				end
				default: acted = 1'b0;
			endcase
			r.edit_mode = edit_on;
			r.field_sel = cursor_sel;
			setting_q.push_back(r);
			return acted;
		endfunction

		function string describe(clock_result_t r);
			return $sformatf("edit=%0d sel=%0d wr=%0d addr=%0d data=%h lcd_v=%0d lcd=%h extra=%0d",
				r.edit_mode, r.field_sel, r.reg_write, r.reg_addr, r.reg_data, r.lcd_valid,
				r.lcd_byte, r.lcd_extra);
		endfunction

		function void check_result(logic [OUT_TDATA_W-1:0] tdata, logic [OUT_TUSER_W-1:0] tuser);
			clock_result_t a;
			clock_result_t e;
			bit            bad;
			a.edit_mode = tdata[0];
			a.field_sel = tdata[3:1];
			a.reg_addr  = tdata[7:4];
			a.reg_data  = tdata[15:8];
			a.lcd_byte  = tdata[23:16];
			a.reg_write = tuser[0];
			a.lcd_valid = tuser[1];
			a.lcd_extra = tuser[2];
			if (setting_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with nothing expected: %s", $realtime, describe(a));
				return;
			end
			e = setting_q.pop_front();
			bad = (a.edit_mode !== e.edit_mode) || (a.field_sel !== e.field_sel)
				|| (a.reg_write !== e.reg_write) || (a.reg_addr !== e.reg_addr)
				|| (a.reg_data !== e.reg_data) || (a.lcd_valid !== e.lcd_valid)
				|| (a.lcd_byte !== e.lcd_byte) || (a.lcd_extra !== e.lcd_extra);
			if (bad) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: expected %s\n            got      %s", $realtime, describe(e),
						describe(a));
			end
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
	logic [CMD_W-1:0]        s_axis_tuser = '0;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]  m_axis_tdata;
	logic [OUT_TUSER_W-1:0]  m_axis_tuser;

	clock_setter_scoreboard  board;
	bit                      send_quiet = 1'b0;
	bit                      recv_quiet = 1'b0;

	clock_field_set_controller i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int pick_gap(bit quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [IN_TDATA_W-1:0] pack_snapshot(logic [6:0] y, logic [3:0] mo,
		logic [4:0] d, logic [2:0] w, logic [4:0] h, logic [5:0] mi, logic [5:0] s);
		return IN_TDATA_W'({s, mi, h, w, d, mo, y});
	endfunction

	function automatic logic [IN_TDATA_W-1:0] random_snapshot();
		if ($urandom_range(0, 4) == 0)
			return pack_snapshot(7'($urandom), 4'($urandom), 5'($urandom), 3'($urandom),
				5'($urandom), 6'($urandom), 6'($urandom));
		return pack_snapshot(7'($urandom_range(0, 99)), 4'($urandom_range(1, 12)),
			5'($urandom_range(1, 31)), 3'($urandom_range(1, 7)), 5'($urandom_range(0, 23)),
			6'($urandom_range(0, 59)), 6'($urandom_range(0, 59)));
	endfunction

	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IN_TDATA_W-1:0] data);
		int gap;
		gap = pick_gap(send_quiet);
		if ($urandom_range(0, 149) == 0)
			send_quiet = !send_quiet;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= data;
		s_axis_tuser <= cmd;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		void'(board.note_input(cmd, data));
	endtask

	task automatic send_key(input logic [CMD_W-1:0] cmd);
		send_item(cmd, random_snapshot());
	endtask

	initial begin
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (!recv_quiet && $urandom_range(0, 3) == 0)
					stall = pick_gap(1'b0);
			end
			if ($urandom_range(0, 199) == 0)
				recv_quiet = !recv_quiet;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_result(m_axis_tdata, m_axis_tuser);
	end

	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		logic [CMD_W-1:0] cmd;
		int               r;
		board = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// keys outside edit mode and unused codes
		send_key(CMD_NEXT);
		send_key(CMD_UP);
		send_key(CMD_DOWN);
		for (int c = CMD_DOWN + 1; c < (1 << CMD_W); c++)
			send_key(CMD_W'(c));
		// snapshot of all ones, above the range of every field but day and weekday, then walk all fields
		send_item(CMD_LOAD, pack_snapshot('1, '1, '1, '1, '1, '1, '1));
		send_key(CMD_MODE);
		send_key(CMD_UP);
		send_key(CMD_DOWN);
		send_key(CMD_NEXT);
		send_key(CMD_UP);
		send_key(CMD_NEXT);
		send_key(CMD_UP);
		send_key(CMD_NEXT);
		send_key(CMD_DOWN);
		send_key(CMD_NEXT);
		send_key(CMD_DOWN);
		send_key(CMD_NEXT);
		send_key(CMD_UP);
		send_key(CMD_NEXT);
		send_key(CMD_DOWN);
		send_key(CMD_NEXT);
		send_item(CMD_LOAD, pack_snapshot('0, '0, '0, '0, '0, '0, '0));
		send_key(CMD_MODE);
		// snapshot below the minimum of month, day and weekday
		send_item(CMD_LOAD, pack_snapshot('0, '0, '0, '0, '0, '0, '0));
		send_key(CMD_MODE);
		send_key(CMD_NEXT);
		send_key(CMD_DOWN);
		send_key(CMD_MODE);

		for (int n = 0; n < 1200; n++) begin
			r = $urandom_range(0, 99);
			if (r < 12)
				cmd = CMD_LOAD;
			else if (r < 20)
				cmd = CMD_MODE;
			else if (r < 40)
				cmd = CMD_NEXT;
			else if (r < 68)
				cmd = CMD_UP;
			else if (r < 95)
				cmd = CMD_DOWN;
			else
				cmd = CMD_W'($urandom_range(CMD_DOWN + 1, (1 << CMD_W) - 1));
			send_key(cmd);
		end
		s_axis_tvalid <= 1'b0;

		while (board.outstanding() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (board.mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
